// ===== sv/prdt_pkg.sv =====
// Package for the pending request dispatch table.
// Slot counts, chain geometry, item and result codes, and the structs passed
// between the top level and the slot cells. No dependencies.
package prdt_pkg;

   localparam int PENDING_SLOTS = 16;
   localparam int HANDLER_SLOTS = 16;

   // one cell per slot position; a cell may carry a pending entry, a handler
   // entry or both
   localparam int CHAIN_LEN = (PENDING_SLOTS > HANDLER_SLOTS) ? PENDING_SLOTS : HANDLER_SLOTS;
   localparam int IDX_W     = (CHAIN_LEN > 1) ? $clog2(CHAIN_LEN) : 1;

   localparam int ID_W    = 32;
   localparam int TYPE_W  = 32;
   localparam int SLOT_W  = 8;
   localparam int CSR_A_W = 8;

   localparam logic [CSR_A_W-1:0] CSR_ID_BASE    = CSR_A_W'(0);
   localparam logic [CSR_A_W-1:0] CSR_DEFAULT_EN = CSR_A_W'(1);

   typedef enum logic [1:0] {
      MODE_SEND_AUTO = 2'd0,
      MODE_SEND_ID   = 2'd1,
      MODE_RECEIVE   = 2'd2,
      MODE_REGISTER  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_DUP     = 3'd2,
      ST_ZERO    = 3'd3,
      ST_REFUSED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      DK_DROP     = 2'd0,
      DK_RESOLVED = 2'd1,
      DK_HANDLER  = 2'd2,
      DK_DEFAULT  = 2'd3
   } kind_type;

   // search result accumulated as it travels down the chain
   typedef struct packed {
      logic             pend_hit;
      logic [IDX_W-1:0] pend_hit_idx;
      logic             pend_free;
      logic [IDX_W-1:0] pend_free_idx;
      logic             hdl_hit;
      logic [IDX_W-1:0] hdl_hit_idx;
      logic             hdl_free;
      logic [IDX_W-1:0] hdl_free_idx;
   } probe_type;

   // table update broadcast to all cells at the end of an item
   typedef struct packed {
      logic              pend_set;
      logic              pend_clr;
      logic [IDX_W-1:0]  pend_idx;
      logic [ID_W-1:0]   pend_id;
      logic              hdl_set;
      logic [IDX_W-1:0]  hdl_idx;
      logic [TYPE_W-1:0] hdl_type;
   } update_type;

endpackage

// ===== sv/prdt_cell.sv =====
// One slot cell of the pending request dispatch table.
// Holds one pending entry and one handler entry, merges its compare into the
// probe from its left neighbor and registers it. Depends on prdt_pkg.
module prdt_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [prdt_pkg::IDX_W-1:0] cell_index,
   input  logic                      has_pending,
   input  logic                      has_handler,
   input  logic [prdt_pkg::ID_W-1:0] key_id,
   input  logic [prdt_pkg::TYPE_W-1:0] key_type,
   input  prdt_pkg::probe_type       probe_in,
   input  prdt_pkg::update_type      update,
   output prdt_pkg::probe_type       probe_out
);
   import prdt_pkg::*;

   logic              pend_valid_ff;
   logic [ID_W-1:0]   pend_id_ff;
   logic              hdl_valid_ff;
   logic [TYPE_W-1:0] hdl_type_ff;
   probe_type         probe_ff;
   probe_type         probe_in_next;

   logic pend_sel;
   logic hdl_sel;

   assign pend_sel = has_pending && (update.pend_idx == cell_index);
   assign hdl_sel  = has_handler && (update.hdl_idx == cell_index);

   // lowest slot wins: only fill a field the left side has not found yet
   always_comb begin
      probe_in_next = probe_in;
      if (!probe_in.pend_hit && has_pending && pend_valid_ff && (pend_id_ff == key_id)) begin
         probe_in_next.pend_hit     = 1'b1;
         probe_in_next.pend_hit_idx = cell_index;
      end
      if (!probe_in.pend_free && has_pending && !pend_valid_ff) begin
         probe_in_next.pend_free     = 1'b1;
         probe_in_next.pend_free_idx = cell_index;
      end
      if (!probe_in.hdl_hit && has_handler && hdl_valid_ff && (hdl_type_ff == key_type)) begin
         probe_in_next.hdl_hit     = 1'b1;
         probe_in_next.hdl_hit_idx = cell_index;
      end
      if (!probe_in.hdl_free && has_handler && !hdl_valid_ff) begin
         probe_in_next.hdl_free     = 1'b1;
         probe_in_next.hdl_free_idx = cell_index;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff <= probe_in_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         hdl_valid_ff  <= 1'b0;
      end else begin
         if (pend_sel && update.pend_set) begin
            pend_valid_ff <= 1'b1;
         end else if (pend_sel && update.pend_clr) begin
            pend_valid_ff <= 1'b0;
         end
         if (hdl_sel && update.hdl_set) begin
            hdl_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pend_sel && update.pend_set) begin
         pend_id_ff <= update.pend_id;
      end
      if (hdl_sel && update.hdl_set) begin
         hdl_type_ff <= update.hdl_type;
      end
   end

   assign probe_out = probe_ff;

endmodule

// ===== sv/pending_request_dispatch_table.sv =====
// Top level of the pending request dispatch table: item control, counter,
// configuration registers and the row of slot cells.
// Depends on prdt_pkg and prdt_cell.
//
// Usage:
//   Input: drive req_* and raise start; the transaction is taken at an edge
//   where start is high and busy is low. busy stays high while the item runs.
//   Output: one result per item, shown on rsp_* for exactly one cycle with
//   rsp_valid high. The receiver cannot stall; it must take it then.
//   Config: csr_valid/csr_ready write channel, csr_index 0 loads the auto ID
//   counter (the ID base), index 1 sets the default handler enable; other
//   indexes are ignored. csr_ready is low while an item runs and while start
//   is high, so a CSR write never lands on the same edge as an item.
// Timing:
//   The search probe walks the cell row one cell per cycle while the item is
//   in S_SCAN; in S_DONE the item is decided and the tables are updated, and
//   the result strobes in the next cycle. A new item may be accepted in the
//   cycle the result is shown.
// Reset: synchronous, active high. Clears all valid bits, the counter, the
//   default enable and the control state. Stored IDs and types are not reset.
module pending_request_dispatch_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_mode,
   input  logic [prdt_pkg::ID_W-1:0]     req_rid,
   input  logic [prdt_pkg::TYPE_W-1:0]   req_mtype,
   input  logic                          req_send_accepted,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_status,
   output logic [1:0]                    rsp_dispatch_kind,
   output logic [prdt_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [prdt_pkg::ID_W-1:0]     rsp_rid_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [prdt_pkg::CSR_A_W-1:0]  csr_index,
   input  logic [31:0]                   csr_wdata
);
   import prdt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;

   // item captured at start
   logic [1:0]        mode_ff;
   logic [ID_W-1:0]   rid_ff;
   logic [TYPE_W-1:0] mtype_ff;
   logic              acc_ff;

   logic [ID_W-1:0]   next_auto_ff;
   logic              default_en_ff;

   logic              rsp_valid_ff;
   status_type        rsp_status_ff, rsp_status_in;
   kind_type          rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;

   probe_type         chain [CHAIN_LEN+1];
   probe_type         probe;
   update_type        decide;
   update_type        update;
   logic              auto_adv;
   logic              accept;
   logic              csr_write;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = !busy && !start;
   assign csr_write = csr_valid && csr_ready;

   // ---------------------------------------------------------------------
   // Cell row. chain[0] is the empty probe; chain[CHAIN_LEN] is the answer
   // once the probe has passed the register of every cell with stable keys.
   // ---------------------------------------------------------------------
   assign chain[0] = '0;
   assign probe    = chain[CHAIN_LEN];

   for (genvar gi = 0; gi < CHAIN_LEN; gi++) begin : g_cell
      prdt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_index  (IDX_W'(gi)),
         .has_pending (gi < PENDING_SLOTS),
         .has_handler (gi < HANDLER_SLOTS),
         .key_id      (rid_ff),
         .key_type    (mtype_ff),
         .probe_in    (chain[gi]),
         .update      (update),
         .probe_out   (chain[gi+1])
      );
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SCAN;
               cnt_in   = '0;
            end
         end
         S_SCAN: begin
            if (cnt_ff == IDX_W'(CHAIN_LEN - 1)) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Decision on the finished probe
   // ---------------------------------------------------------------------
   always_comb begin
      decide        = '0;
      auto_adv      = 1'b0;
      rsp_status_in = ST_OK;
      rsp_kind_in   = DK_DROP;
      rsp_slot_in   = '0;
      rsp_id_in     = '0;
      unique case (mode_type'(mode_ff))
         MODE_SEND_AUTO: begin
            if (!probe.pend_free) begin
               rsp_status_in = ST_FULL;
            end else begin
               auto_adv = 1'b1;   // counter moves even if the send is refused
               if (!acc_ff) begin
                  rsp_status_in = ST_REFUSED;
               end else begin
                  decide.pend_set = 1'b1;
                  decide.pend_idx = probe.pend_free_idx;
                  decide.pend_id  = next_auto_ff;
                  rsp_slot_in     = SLOT_W'(probe.pend_free_idx);
                  rsp_id_in       = next_auto_ff;
               end
            end
         end
         MODE_SEND_ID: begin
            priority if (rid_ff == '0) begin
               rsp_status_in = ST_ZERO;
            end else if (probe.pend_hit) begin
               rsp_status_in = ST_DUP;
            end else if (!probe.pend_free) begin
               rsp_status_in = ST_FULL;
            end else if (!acc_ff) begin
               rsp_status_in = ST_REFUSED;
            end else begin
               decide.pend_set = 1'b1;
               decide.pend_idx = probe.pend_free_idx;
               decide.pend_id  = rid_ff;
               rsp_slot_in     = SLOT_W'(probe.pend_free_idx);
               rsp_id_in       = rid_ff;
            end
         end
         MODE_RECEIVE: begin
            priority if (probe.pend_hit) begin
               decide.pend_clr = 1'b1;
               decide.pend_idx = probe.pend_hit_idx;
               rsp_kind_in     = DK_RESOLVED;
               rsp_slot_in     = SLOT_W'(probe.pend_hit_idx);
               rsp_id_in       = rid_ff;
            end else if (probe.hdl_hit) begin
               rsp_kind_in = DK_HANDLER;
               rsp_slot_in = SLOT_W'(probe.hdl_hit_idx);
            end else if (default_en_ff) begin
               rsp_kind_in = DK_DEFAULT;
            end else begin
               rsp_kind_in = DK_DROP;
            end
         end
         MODE_REGISTER: begin
            priority if (probe.hdl_hit) begin
               rsp_slot_in = SLOT_W'(probe.hdl_hit_idx);
            end else if (probe.hdl_free) begin
               decide.hdl_set  = 1'b1;
               decide.hdl_idx  = probe.hdl_free_idx;
               decide.hdl_type = mtype_ff;
               rsp_slot_in     = SLOT_W'(probe.hdl_free_idx);
            end else begin
               rsp_status_in = ST_FULL;
            end
         end
         default: begin
            rsp_status_in = ST_OK;
         end
      endcase
   end

   // tables change only in the decide cycle
   always_comb begin
      update = decide;
      if (state_ff != S_DONE) begin
         update.pend_set = 1'b0;
         update.pend_clr = 1'b0;
         update.hdl_set  = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         next_auto_ff  <= '0;
         default_en_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= (state_ff == S_DONE);
         if (csr_write && (csr_index == CSR_ID_BASE)) begin
            next_auto_ff <= csr_wdata;
         end else if ((state_ff == S_DONE) && auto_adv) begin
            next_auto_ff <= next_auto_ff + 1'b1;
         end
         if (csr_write && (csr_index == CSR_DEFAULT_EN)) begin
            default_en_ff <= csr_wdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_mode;
         rid_ff   <= req_rid;
         mtype_ff <= req_mtype;
         acc_ff   <= req_send_accepted;
      end
      if (state_ff == S_DONE) begin
         rsp_status_ff <= rsp_status_in;
         rsp_kind_ff   <= rsp_kind_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_id_ff     <= rsp_id_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_dispatch_kind = rsp_kind_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_rid_out       = rsp_id_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_DONE))
      else $error("result strobe without a decide cycle");

   a_keys_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |=> $stable(rid_ff) && $stable(mtype_ff))
      else $error("search keys changed during the scan");

   a_one_pend_op: assert property (@(posedge clock) disable iff (reset)
      !(update.pend_set && update.pend_clr))
      else $error("pending slot set and cleared together");

   a_pend_idx_range: assert property (@(posedge clock) disable iff (reset)
      (update.pend_set || update.pend_clr) |-> (update.pend_idx <= IDX_W'(PENDING_SLOTS - 1)))
      else $error("pending update beyond the table");

   a_counter_step: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && auto_adv) |=> (next_auto_ff == $past(next_auto_ff) + 1'b1))
      else $error("auto ID counter did not advance by one");

endmodule
